### hw/rtl/lcdws_pkg.sv
// types, codes and sequencing tables shared by the lcd write sequencer
package lcdws_pkg;

  // request codes
  localparam logic [2:0] REQ_INIT   = 3'd0;
  localparam logic [2:0] REQ_CMD    = 3'd1;
  localparam logic [2:0] REQ_CHAR   = 3'd2;
  localparam logic [2:0] REQ_CURSOR = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  // configuration register indexes
  localparam logic CFG_BUS_WIDTH_8 = 1'b0;

  // lcd command bytes
  localparam logic [7:0] LCD_CMD_CLR   = 8'h01;
  localparam logic [7:0] LCD_ENTRY     = 8'h06;
  localparam logic [7:0] LCD_DISPLAY   = 8'h0C;
  localparam logic [7:0] LCD_FUNC_4BIT = 8'h28;
  localparam logic [7:0] LCD_FUNC_8BIT = 8'h38;
  localparam logic [7:0] LCD_WAKE_8BIT = 8'h30;
  localparam logic [7:0] LCD_WAKE_NIB  = 8'h03;
  localparam logic [7:0] LCD_SET_4BIT  = 8'h02;

  localparam logic [5:0] POWER_UP_WAIT_MS = 6'd40;
  localparam logic [2:0] CMD_WAIT_MS      = 3'd2;
  localparam logic [2:0] CHAR_WAIT_MS     = 3'd1;
  localparam logic [3:0] INIT4_LAST_STEP  = 4'd11;
  localparam logic [3:0] INIT8_LAST_STEP  = 4'd6;

  typedef enum logic [1:0] {
    OP_INIT,
    OP_BYTE,
    OP_ERROR
  } op_e;

  // one classified request waiting for the back end
  typedef struct packed {
    op_e        op;
    logic       bus8;
    logic       rs;
    logic [7:0] data;
    logic [2:0] after;
  } entry_t;

  // one result word
  typedef struct packed {
    logic       rs;
    logic [7:0] bus;
    logic [5:0] pre;
    logic [2:0] after;
    logic       error;
    logic       last;
  } xfer_t;

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] b;
    case (row)
      2'd0: b = 8'h80;
      2'd1: b = 8'hC0;
      2'd2: b = 8'h94;
      default: b = 8'hD4;
    endcase
    return b;
  endfunction

  // one byte, split into nibbles on a 4-bit bus
  function automatic xfer_t byte_xfer(input entry_t e, input logic [3:0] step);
    xfer_t x;
    x.rs     = e.rs;
    x.pre    = '0;
    x.error  = 1'b0;
    if (e.bus8) begin
      x.bus   = e.data;
      x.after = e.after;
      x.last  = 1'b1;
    end else if (step == 4'd0) begin
      x.bus   = {4'h0, e.data[7:4]};
      x.after = '0;
      x.last  = 1'b0;
    end else begin
      x.bus   = {4'h0, e.data[3:0]};
      x.after = e.after;
      x.last  = 1'b1;
    end
    return x;
  endfunction

  // power-up sequence, one transfer per step
  function automatic xfer_t init_xfer(input logic bus8, input logic [3:0] step);
    xfer_t      x;
    xfer_t      nx;
    logic [7:0] cmd;
    entry_t     e;
    x.rs     = 1'b0;
    x.error  = 1'b0;
    x.pre    = (step == 4'd0) ? POWER_UP_WAIT_MS : 6'd0;
    x.bus    = '0;
    x.after  = '0;
    cmd      = '0;
    if (bus8) begin
      case (step)
        4'd0: begin x.bus = LCD_WAKE_8BIT; x.after = 3'd7; end
        4'd1: begin x.bus = LCD_WAKE_8BIT; x.after = 3'd3; end
        4'd2: begin x.bus = LCD_WAKE_8BIT; x.after = CMD_WAIT_MS; end
        4'd3: begin x.bus = LCD_FUNC_8BIT; x.after = CMD_WAIT_MS; end
        4'd4: begin x.bus = LCD_DISPLAY;   x.after = CMD_WAIT_MS; end
        4'd5: begin x.bus = LCD_ENTRY;     x.after = CMD_WAIT_MS; end
        default: begin x.bus = LCD_CMD_CLR; x.after = CMD_WAIT_MS; end
      endcase
      x.last = (step == INIT8_LAST_STEP);
    end else begin
      case (step)
        4'd0: begin x.bus = LCD_WAKE_NIB; x.after = 3'd5; end
        4'd1: begin x.bus = LCD_WAKE_NIB; x.after = 3'd1; end
        4'd2: x.bus = LCD_WAKE_NIB;
        4'd3: x.bus = LCD_SET_4BIT;
        default: begin
          case (step[2:1])
            2'd2: cmd = LCD_FUNC_4BIT;
            2'd3: cmd = LCD_DISPLAY;
            2'd0: cmd = LCD_ENTRY;
            default: cmd = LCD_CMD_CLR;
          endcase
          e.op    = OP_BYTE;
          e.bus8  = 1'b0;
          e.rs    = 1'b0;
          e.data  = cmd;
          e.after = CMD_WAIT_MS;
          nx      = byte_xfer(e, {3'd0, step[0]});
          x.bus   = nx.bus;
          x.after = nx.after;
        end
      endcase
      x.last = (step == INIT4_LAST_STEP);
    end
    return x;
  endfunction

endpackage

### hw/rtl/lcdws_front.sv
// front end: takes requests and turns them into queue entries
module lcdws_front (
  input  logic                 in_valid_i,
  input  logic [2:0]           req_type_i,
  input  logic [7:0]           data_byte_i,
  input  logic [2:0]           row_i,
  input  logic [5:0]           col_i,
  input  logic                 bus8_i,
  input  logic                 full_i,
  output logic                 in_stall_o,
  output logic                 push_o,
  output lcdws_pkg::entry_t    entry_o
);
  import lcdws_pkg::*;

  logic known;

  assign in_stall_o = full_i;

  always_comb begin
    known         = 1'b1;
    entry_o.op    = OP_BYTE;
    entry_o.bus8  = bus8_i;
    entry_o.rs    = 1'b0;
    entry_o.data  = data_byte_i;
    entry_o.after = CMD_WAIT_MS;
    case (req_type_i)
      REQ_INIT:  entry_o.op = OP_INIT;
      REQ_CMD:   ;
      REQ_CHAR: begin
        entry_o.rs    = 1'b1;
        entry_o.after = CHAR_WAIT_MS;
      end
      REQ_CURSOR: begin
        if (row_i[2]) entry_o.op = OP_ERROR;
        entry_o.data = row_base(row_i[1:0]) + {2'b00, col_i};
      end
      REQ_CLEAR: entry_o.data = LCD_CMD_CLR;
      default:   known = 1'b0; // unknown codes are taken and dropped
    endcase
  end

  assign push_o = in_valid_i && !full_i && known;

endmodule

### hw/rtl/lcdws_queue.sv
// small queue of classified requests between front and back end
module lcdws_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lcdws_pkg::entry_t    entry_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output lcdws_pkg::entry_t    entry_o
);
  import lcdws_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == FULL_CNT);
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    else if (!do_push && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT) else $error("queue count overflow");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
    else $error("push lost");
  a_ptrs_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q)) else $error("pointer skew");

endmodule

### hw/rtl/lcdws_back.sv
// back end: steps through the transfers of the head entry
module lcdws_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  lcdws_pkg::entry_t    head_i,
  output logic                 pop_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output lcdws_pkg::xfer_t     out_o
);
  import lcdws_pkg::*;

  logic [3:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  xfer_t      out_q, cur;
  logic       fire;

  always_comb begin
    case (head_i.op)
      OP_INIT: cur = init_xfer(head_i.bus8, step_q);
      OP_BYTE: cur = byte_xfer(head_i, step_q);
      default: begin
        cur       = '0;
        cur.error = 1'b1;
        cur.last  = 1'b1;
      end
    endcase
  end

  // output register frees up when empty or taken this cycle
  assign fire  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = fire && cur.last;

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (fire) begin
      step_d      = cur.last ? 4'd0 : step_q + 4'd1;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_q <= cur;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= INIT4_LAST_STEP) else $error("step out of range");
  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.error |-> out_q.last && out_q.bus == '0)
    else $error("error word malformed");
  a_pre_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.pre != '0 |-> out_q.pre == POWER_UP_WAIT_MS && !out_q.rs)
    else $error("bad power-up wait");
  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> step_q == 4'd0) else $error("step not rewound");

endmodule

### hw/rtl/char_lcd_write_sequencer_unit.sv
// top level of the character lcd write sequencer
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------
//  in      | input     | in_valid_i/in_stall_o | req_type, data_byte, row, col
//  out     | output    | out_valid_o/out_stall_i | rs_level, bus_value, wait_*, error, last
//  cfg     | input     | apb psel/penable      | bus_width_8 at byte address 0
//
//  one transfer word leaves per cycle from the back end's output register, unless
//  out_stall_i holds it or the queue is empty; an init request gives 12 words on a
//  4-bit bus and 7 on an 8-bit bus, a byte 2 or 1, a bad cursor row 1 error word;
//  unknown codes are taken and dropped; requests are taken while the queue has room,
//  so the front keeps working while a result word sits stalled at the output
//  reset clears queue, step counter, output valid and sets a 4-bit bus
module char_lcd_write_sequencer_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  data_byte_i,
  input  logic [2:0]  row_i,
  input  logic [5:0]  col_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        rs_level_o,
  output logic [7:0]  bus_value_o,
  output logic [5:0]  wait_before_ms_o,
  output logic [2:0]  wait_after_ms_o,
  output logic        error_o,
  output logic        last_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lcdws_pkg::*;

  logic   bus8_q, bus8_d;
  logic   cfg_wr;
  logic   full, push, pop, head_valid;
  entry_t entry, head;
  xfer_t  xfer;

  // config register, word index taken from paddr bit 2
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign bus8_d = (cfg_wr && (paddr[2] == CFG_BUS_WIDTH_8)) ? pwdata[0] : bus8_q;
  assign prdata = (paddr[2] == CFG_BUS_WIDTH_8) ? {31'd0, bus8_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus8_q <= 1'b0;
    end else begin
      bus8_q <= bus8_d;
    end
  end

  // classify: the bus width is latched into each entry
  lcdws_front u_front (
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .data_byte_i(data_byte_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .bus8_i     (bus8_q),
    .full_i     (full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .entry_o    (entry)
  );

  // decouples request intake from transfer sequencing
  lcdws_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (pop),
    .full_o (full),
    .valid_o(head_valid),
    .entry_o(head)
  );

  // sequencer: pops the head after its last word
  lcdws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (xfer)
  );

  assign rs_level_o       = xfer.rs;
  assign bus_value_o      = xfer.bus;
  assign wait_before_ms_o = xfer.pre;
  assign wait_after_ms_o  = xfer.after;
  assign error_o          = xfer.error;
  assign last_o           = xfer.last;

endmodule
